>>> rtl/core/sepi_pkg.sv
package sepi_pkg;

	localparam int FRAC_W = 16;
	localparam int EXP_W  = 6;
	localparam int LOG_W  = EXP_W + FRAC_W;
	localparam int L1_W   = 19;

	// 2^16 * log2 of the fixed-point scales (Q56 magnitude, Q17 for the inner log)
	localparam logic [LOG_W-1:0] L1_OFFSET = LOG_W'(56 * 65536);
	localparam logic [LOG_W-1:0] S_OFFSET  = LOG_W'(17 * 65536);

	localparam logic [16:0] PSIZE_MAX   = 17'd65536;
	localparam logic [16:0] PSIZE_RESET = 17'd256;

	// cycles from an accepted request to its result strobe
	localparam int LATENCY = 73;

	typedef struct packed {
		logic signed [31:0] z_real;
		logic signed [31:0] z_imag;
		logic [31:0]        iter_count;
	} sepi_req_t;

	typedef struct packed {
		logic [15:0] palette_index;
		logic        invalid;
	} sepi_rsp_t;

	// one squaring step of the log: floor(m*m / 2^62), renormalized, top bit is the fraction bit
	function automatic logic [63:0] sepi_step(input logic [61:0] p11, input logic [62:0] p01,
		input logic [63:0] p00);
		logic [125:0] full;
		logic [63:0]  sq;
		full = {p11, 64'd0} + {30'd0, p01, 33'd0} + {62'd0, p00};
		sq = full[125:62];
		return sq[63] ? {1'b1, sq[63:1]} : {1'b0, sq[62:0]};
	endfunction

endpackage

>>> rtl/core/sepi_log2.sv
module sepi_log2 import sepi_pkg::*; #(
	parameter int TAG_W = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [63:0]      in_v,
	input  logic [TAG_W-1:0] in_tag,
	output logic             out_valid,
	output logic [LOG_W-1:0] out_log,
	output logic [TAG_W-1:0] out_tag
);

	localparam int ITERS = FRAC_W;

	logic [EXP_W-1:0] top_bit;
	logic             vld_s1;
	logic [EXP_W-1:0] exp_s1;
	logic [63:0]      v_s1;
	logic [TAG_W-1:0] tag_s1;

	// per squaring step: a-stage holds partial products, m-stage the renormalized mantissa
	logic             vld_m_s  [0:ITERS];
	logic [62:0]      mant_s   [0:ITERS];
	logic [FRAC_W-1:0] frac_s  [0:ITERS];
	logic [EXP_W-1:0] exp_m_s  [0:ITERS];
	logic [TAG_W-1:0] tag_m_s  [0:ITERS];
	logic             vld_a_s  [0:ITERS-1];
	logic [61:0]      p11_s    [0:ITERS-1];
	logic [62:0]      p01_s    [0:ITERS-1];
	logic [63:0]      p00_s    [0:ITERS-1];
	logic [FRAC_W-1:0] frac_a_s[0:ITERS-1];
	logic [EXP_W-1:0] exp_a_s  [0:ITERS-1];
	logic [TAG_W-1:0] tag_a_s  [0:ITERS-1];
	logic [63:0]      step_w   [0:ITERS-1];

	always_comb begin
		top_bit = '0;
		for (int i = 0; i < 64; i++) begin
			if (in_v[i]) begin
				top_bit = EXP_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			vld_m_s[0] <= 1'b0;
		end else begin
			vld_s1     <= in_valid;
			vld_m_s[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		exp_s1 <= top_bit;
		v_s1   <= in_v;
		tag_s1 <= in_tag;
		exp_m_s[0] <= exp_s1;
		tag_m_s[0] <= tag_s1;
		frac_s[0]  <= '0;
		if (exp_s1 == EXP_W'(63)) begin
			mant_s[0] <= v_s1[63:1];
		end else begin
			mant_s[0] <= v_s1[62:0] << (EXP_W'(62) - exp_s1);
		end
	end

	for (genvar g = 0; g < ITERS; g++) begin : g_iter
		assign step_w[g] = sepi_step(p11_s[g], p01_s[g], p00_s[g]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_a_s[g]     <= 1'b0;
				vld_m_s[g + 1] <= 1'b0;
			end else begin
				vld_a_s[g]     <= vld_m_s[g];
				vld_m_s[g + 1] <= vld_a_s[g];
			end
		end

		always_ff @(posedge clk) begin
			p11_s[g]    <= 62'(mant_s[g][62:32]) * 62'(mant_s[g][62:32]);
			p01_s[g]    <= 63'(mant_s[g][62:32]) * 63'(mant_s[g][31:0]);
			p00_s[g]    <= 64'(mant_s[g][31:0]) * 64'(mant_s[g][31:0]);
			frac_a_s[g] <= frac_s[g];
			exp_a_s[g]  <= exp_m_s[g];
			tag_a_s[g]  <= tag_m_s[g];
			mant_s[g + 1]  <= step_w[g][62:0];
			frac_s[g + 1]  <= {frac_a_s[g][FRAC_W-2:0], step_w[g][63]};
			exp_m_s[g + 1] <= exp_a_s[g];
			tag_m_s[g + 1] <= tag_a_s[g];
		end
	end

	assign out_valid = vld_m_s[ITERS];
	assign out_log   = {exp_m_s[ITERS], frac_s[ITERS]};
	assign out_tag   = tag_m_s[ITERS];

endmodule

>>> rtl/core/smooth_escape_palette_index.sv
// Smooth escape-time palette index. Each request (final z in Q4.28 and the escape
// iteration) yields one result, a new request may enter every cycle and busy never
// rises. Each result passes through the input squares, two log2 pipelines, each
// running sixteen squaring steps of two stages, and the output scaling. Results come as
// a one-cycle done strobe and cannot be held off. palette_size is written through
// cfg_we/cfg_wdata by the user only while no request is in flight (not enforced).
module smooth_escape_palette_index import sepi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  sepi_req_t   req,
	output logic        done,
	output sepi_rsp_t   rsp,
	input  logic        cfg_we,
	input  logic [16:0] cfg_wdata
);

	localparam int TAG_W = 33;

	logic [16:0] palette_size_q;
	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [62:0] sq_re_s1, sq_im_s1;
	logic [31:0] iter_s1, iter_s3;
	logic [63:0] sum_s2;
	logic [31:0] iter_s2;
	logic        zero_s2;

	logic             log1_valid, log2_valid;
	logic [LOG_W-1:0] log1_out, log2_out;
	logic [TAG_W-1:0] log1_tag, log2_tag;

	logic [L1_W-1:0]  l1_s3;
	logic             inv_s3;

	logic signed [LOG_W:0] s_w;
	logic [50:0]      x_w;
	logic [15:0]      frac_s4;
	logic             zero_idx_s4, inv_s4;

	logic [16:0]      psize_w;
	logic [32:0]      prod_w;
	sepi_rsp_t        rsp_s5;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_size_q <= PSIZE_RESET;
		end else if (cfg_we) begin
			palette_size_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= log1_valid;
			vld_s4 <= log2_valid;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		sq_re_s1 <= 63'(64'(req.z_real * req.z_real));
		sq_im_s1 <= 63'(64'(req.z_imag * req.z_imag));
		iter_s1  <= req.iter_count;
		sum_s2   <= 64'(sq_re_s1) + 64'(sq_im_s1);
		zero_s2  <= (sq_re_s1 == '0) && (sq_im_s1 == '0);
		iter_s2  <= iter_s1;
	end

	sepi_log2 #(.TAG_W(TAG_W)) u_log_mag (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s2),
		.in_v     (sum_s2),
		.in_tag   ({iter_s2, zero_s2}),
		.out_valid(log1_valid),
		.out_log  (log1_out),
		.out_tag  (log1_tag)
	);

	// magnitude at or below one: log of the log is undefined
	always_ff @(posedge clk) begin
		l1_s3   <= L1_W'(log1_out - L1_OFFSET);
		inv_s3  <= log1_tag[0] || (log1_out <= L1_OFFSET);
		iter_s3 <= log1_tag[TAG_W-1:1];
	end

	sepi_log2 #(.TAG_W(TAG_W)) u_log_smooth (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s3),
		.in_v     (64'(l1_s3)),
		.in_tag   ({iter_s3, inv_s3}),
		.out_valid(log2_valid),
		.out_log  (log2_out),
		.out_tag  (log2_tag)
	);

	assign s_w = $signed({1'b0, log2_out}) - $signed({1'b0, S_OFFSET});
	assign x_w = {2'b00, 33'(log2_tag[TAG_W-1:1]) + 33'd1, 16'd0}
		- {{(51 - LOG_W - 1){s_w[LOG_W]}}, s_w};

	always_ff @(posedge clk) begin
		frac_s4     <= x_w[15:0];
		zero_idx_s4 <= x_w[50] || log2_tag[0];
		inv_s4      <= log2_tag[0];
	end

	assign psize_w = (palette_size_q > PSIZE_MAX) ? PSIZE_MAX : palette_size_q;
	assign prod_w  = 33'(frac_s4) * 33'(psize_w);

	always_ff @(posedge clk) begin
		rsp_s5.palette_index <= zero_idx_s4 ? 16'd0 : prod_w[31:16];
		rsp_s5.invalid       <= inv_s4;
	end

	assign done = vld_s5;
	assign rsp  = rsp_s5;

endmodule

>>> rtl/core/sepi_checker.sv
module sepi_checker import sepi_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input sepi_rsp_t   rsp,
	input logic        cfg_we,
	input logic [16:0] cfg_wdata
);

	logic [16:0] psize_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psize_q <= PSIZE_RESET;
		end else if (cfg_we) begin
			psize_q <= cfg_wdata;
		end
	end

	// every result answers a request a fixed time earlier
	a_done_follows_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without matching request");

	a_req_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##73 done)
		else $error("request produced no result");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.invalid) |-> (rsp.palette_index == 16'd0))
		else $error("invalid result with nonzero index");

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && psize_q != 17'd0 && psize_q <= PSIZE_MAX)
		|-> (17'(rsp.palette_index) < psize_q))
		else $error("index beyond palette size");

endmodule

bind smooth_escape_palette_index sepi_checker u_sepi_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.rsp      (rsp),
	.cfg_we   (cfg_we),
	.cfg_wdata(cfg_wdata)
);
